FILE: src/smx_pkg.sv
// ----------------------------------------------------------------------------
// smx_pkg
// Shared widths, opcodes and error codes for the stack machine executor.
// ----------------------------------------------------------------------------
package smx_pkg;

	// data path width
	localparam int DATA_W = 32;

	// default stack size in words
	localparam int STACK_DEPTH_DEF = 128;

	// opcodes carried in req_type
	localparam logic [2:0] OP_PUSH  = 3'd0;
	localparam logic [2:0] OP_ADD   = 3'd1;
	localparam logic [2:0] OP_SUB   = 3'd2;
	localparam logic [2:0] OP_MUL   = 3'd3;
	localparam logic [2:0] OP_DIV   = 3'd4;
	localparam logic [2:0] OP_EMIT  = 3'd5;
	localparam logic [2:0] OP_DUP   = 3'd6;
	localparam logic [2:0] OP_SWAP  = 3'd7;

	// error codes reported in error_code
	localparam logic [2:0] ERR_OK        = 3'd0;
	localparam logic [2:0] ERR_OVERFLOW  = 3'd1;
	localparam logic [2:0] ERR_UNDERFLOW = 3'd2;
	localparam logic [2:0] ERR_DIVZERO   = 3'd3;
	localparam logic [2:0] ERR_SWAPSHORT = 3'd4;

endpackage

FILE: src/smx_div.sv
// ----------------------------------------------------------------------------
// smx_div
// Iterative signed divider, one quotient bit per cycle, truncating toward
// zero. The minimum value divided by minus one wraps to the minimum value.
// ----------------------------------------------------------------------------
module smx_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [smx_pkg::DATA_W-1:0]     dividend,
	input  logic [smx_pkg::DATA_W-1:0]     divisor,
	output logic                           done,
	output logic [smx_pkg::DATA_W-1:0]     quotient
);

	localparam int W  = smx_pkg::DATA_W;
	localparam int CW = $clog2(W + 1);

	logic          run_q;
	logic [CW-1:0] cnt_q;
	logic          neg_q;
	logic          done_q;
	logic [W:0]    rem_q;
	logic [W-1:0]  quo_q;
	logic [W-1:0]  dvs_q;

	logic [W:0]    rem_sh;
	logic [W:0]    rem_sub;
	logic          take;

	// one restoring step
	assign rem_sh  = {rem_q[W-1:0], quo_q[W-1]};
	assign rem_sub = rem_sh - {1'b0, dvs_q};
	assign take    = ~rem_sub[W];

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CW'(W);
			end else if (run_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// data path: magnitudes in, shift and subtract
	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[W-1] ^ divisor[W-1];
			quo_q <= dividend[W-1] ? (W'(0) - dividend) : dividend;
			dvs_q <= divisor[W-1] ? (W'(0) - divisor) : divisor;
			rem_q <= '0;
		end else if (run_q) begin
			rem_q <= take ? rem_sub : rem_sh;
			quo_q <= {quo_q[W-2:0], take};
		end
	end

	assign done     = done_q;
	assign quotient = neg_q ? (W'(0) - quo_q) : quo_q;

endmodule

FILE: src/stack_machine_executor_core.sv
// ----------------------------------------------------------------------------
// stack_machine_executor_core
// Executes one stack-machine instruction per item on a stack held in a
// synchronous memory.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: an item (req_type, push_value) is taken on a rising edge
//   with start high and busy low. busy stays high while the item is worked.
//   Result channel: done is high for one cycle with print_valid, print_value,
//   error_code and stack_depth; the receiver cannot stall, it must take it.
//   busy is already low in the done cycle, so the next item may start then.
// Path: push and limit errors finish in ST_DEC; print and dup in ST_RD1;
//   swap in ST_SWPW; add, sub, mul and divide by zero in ST_EXEC; divide
//   in ST_DIVW. The memory has one read and one write port, so operands
//   are fetched one per cycle, and the divider retires one quotient bit
//   a cycle.
// Reset: depth clears to zero at once; stack words are not cleared, as no
//   word below the depth is ever unwritten.
// stack_depth is the depth masked to 8 bits.
// ----------------------------------------------------------------------------
module stack_machine_executor_core #(
	parameter int STACK_DEPTH = smx_pkg::STACK_DEPTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [2:0]                 req_type,
	input  logic signed [31:0]         push_value,
	output logic                       done,
	output logic                       print_valid,
	output logic signed [31:0]         print_value,
	output logic [2:0]                 error_code,
	output logic [7:0]                 stack_depth
);

	localparam int W  = smx_pkg::DATA_W;
	localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int DW = $clog2(STACK_DEPTH + 1);

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_DEC  = 7'b0000010,
		ST_RD1  = 7'b0000100,
		ST_RD2  = 7'b0001000,
		ST_EXEC = 7'b0010000,
		ST_DIVW = 7'b0100000,
		ST_SWPW = 7'b1000000
	} state_t;

	state_t        state_q, state_d;
	logic [DW-1:0] depth_q, depth_d;
	logic [2:0]    op_q;
	logic [W-1:0]  imm_q;
	logic [W-1:0]  a_q, a_d;
	logic [W-1:0]  b_q, b_d;
	logic          done_q, done_d;
	logic          pv_q, pv_d;
	logic [W-1:0]  pval_q, pval_d;
	logic [2:0]    err_q, err_d;

	// memory port signals
	logic [W-1:0]  mem [STACK_DEPTH];
	logic          we;
	logic [AW-1:0] wa, ra;
	logic [W-1:0]  wd;
	logic [W-1:0]  rdata_q;

	logic [AW-1:0] addr_new, addr_top, addr_sec;
	logic          accept;
	logic          full, lt1, lt2;
	logic          div_start, div_done;
	logic [W-1:0]  div_q;
	logic [DW+7:0] depth_ext;

	assign accept   = start & ~busy;
	assign addr_new = depth_q[AW-1:0];
	assign addr_top = addr_new - AW'(1);
	assign addr_sec = addr_new - AW'(2);
	assign full     = depth_q >= DW'(STACK_DEPTH);
	assign lt1      = depth_q < DW'(1);
	assign lt2      = depth_q < DW'(2);

	// divider
	smx_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (a_q),
		.divisor  (b_q),
		.done     (div_done),
		.quotient (div_q)
	);

	// stack memory, synchronous read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		rdata_q <= mem[ra];
	end

	// sequencer
	always_comb begin
		state_d   = state_q;
		depth_d   = depth_q;
		a_d       = a_q;
		b_d       = b_q;
		done_d    = 1'b0;
		pv_d      = pv_q;
		pval_d    = pval_q;
		err_d     = err_q;
		we        = 1'b0;
		wa        = addr_new;
		wd        = imm_q;
		ra        = addr_top;
		div_start = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_DEC;
					pv_d    = 1'b0;
					pval_d  = '0;
					err_d   = smx_pkg::ERR_OK;
				end
			end
			// check limits, push completes here
			ST_DEC: begin
				priority if (op_q == smx_pkg::OP_PUSH) begin
					if (full) begin
						err_d = smx_pkg::ERR_OVERFLOW;
					end else begin
						we      = 1'b1;
						depth_d = depth_q + DW'(1);
					end
					done_d  = 1'b1;
					state_d = ST_IDLE;
				end else if (op_q == smx_pkg::OP_SWAP) begin
					if (lt2) begin
						err_d   = smx_pkg::ERR_SWAPSHORT;
						done_d  = 1'b1;
						state_d = ST_IDLE;
					end else begin
						state_d = ST_RD1;
					end
				end else if (op_q == smx_pkg::OP_EMIT || op_q == smx_pkg::OP_DUP) begin
					if (lt1) begin
						err_d   = smx_pkg::ERR_UNDERFLOW;
						done_d  = 1'b1;
						state_d = ST_IDLE;
					end else if (op_q == smx_pkg::OP_DUP && full) begin
						err_d   = smx_pkg::ERR_OVERFLOW;
						done_d  = 1'b1;
						state_d = ST_IDLE;
					end else begin
						state_d = ST_RD1;
					end
				end else begin
					if (lt2) begin
						err_d   = smx_pkg::ERR_UNDERFLOW;
						done_d  = 1'b1;
						state_d = ST_IDLE;
					end else begin
						state_d = ST_RD1;
					end
				end
			end
			// top word arrives
			ST_RD1: begin
				b_d = rdata_q;
				ra  = addr_sec;
				priority if (op_q == smx_pkg::OP_EMIT) begin
					pv_d    = 1'b1;
					pval_d  = rdata_q;
					depth_d = depth_q - DW'(1);
					done_d  = 1'b1;
					state_d = ST_IDLE;
				end else if (op_q == smx_pkg::OP_DUP) begin
					we      = 1'b1;
					wd      = rdata_q;
					depth_d = depth_q + DW'(1);
					done_d  = 1'b1;
					state_d = ST_IDLE;
				end else begin
					state_d = ST_RD2;
				end
			end
			// second word arrives
			ST_RD2: begin
				a_d = rdata_q;
				if (op_q == smx_pkg::OP_SWAP) begin
					we      = 1'b1;
					wa      = addr_top;
					wd      = rdata_q;
					state_d = ST_SWPW;
				end else begin
					state_d = ST_EXEC;
				end
			end
			ST_SWPW: begin
				we      = 1'b1;
				wa      = addr_sec;
				wd      = b_q;
				done_d  = 1'b1;
				state_d = ST_IDLE;
			end
			// arithmetic and write back
			ST_EXEC: begin
				wa = addr_sec;
				priority if (op_q == smx_pkg::OP_DIV) begin
					if (b_q == '0) begin
						err_d   = smx_pkg::ERR_DIVZERO;
						done_d  = 1'b1;
						state_d = ST_IDLE;
					end else begin
						div_start = 1'b1;
						state_d   = ST_DIVW;
					end
				end else begin
					we      = 1'b1;
					depth_d = depth_q - DW'(1);
					done_d  = 1'b1;
					state_d = ST_IDLE;
					if (op_q == smx_pkg::OP_ADD) begin
						wd = a_q + b_q;
					end else if (op_q == smx_pkg::OP_SUB) begin
						wd = a_q - b_q;
					end else begin
						wd = a_q * b_q;
					end
				end
			end
			ST_DIVW: begin
				wa = addr_sec;
				wd = div_q;
				if (div_done) begin
					we      = 1'b1;
					depth_d = depth_q - DW'(1);
					done_d  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			depth_q <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			depth_q <= depth_d;
			done_q  <= done_d;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= req_type;
			imm_q <= push_value;
		end
		a_q    <= a_d;
		b_q    <= b_d;
		pv_q   <= pv_d;
		pval_q <= pval_d;
		err_q  <= err_d;
	end

	assign depth_ext   = {8'd0, depth_q};
	assign busy        = (state_q != ST_IDLE);
	assign done        = done_q;
	assign print_valid = pv_q;
	assign print_value = pval_q;
	assign error_code  = err_q;
	assign stack_depth = depth_ext[7:0];

`ifndef SYNTHESIS
	a_depth_range: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= DW'(STACK_DEPTH))
		else $error("stack depth beyond capacity");

	a_done_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(state_q != ST_IDLE))
		else $error("result without an item in work");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("accepted item did not raise busy");

	a_print_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && pv_q) |-> (err_q == smx_pkg::ERR_OK))
		else $error("print result carries an error");

	a_err_depth: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && err_q != smx_pkg::ERR_OK) |-> $stable(depth_q))
		else $error("failed instruction changed the depth");
`endif

endmodule
